// File: hdl/hw565_pkg.sv
// ----------------------------------------------------------------------------
// hw565_pkg
// Shared types and constants for the hue wheel to RGB565 mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package hw565_pkg;

  localparam int unsigned NumCh    = 3;
  localparam int unsigned DivSteps = 8;

  localparam int unsigned ChR = 0;
  localparam int unsigned ChG = 1;
  localparam int unsigned ChB = 2;

  localparam logic [7:0] ThirdMul    = 8'd85;
  localparam logic [7:0] TwoThirdMul = 8'd170;
  localparam logic [7:0] Lvl255      = 8'd255;
  localparam logic [7:0] Lvl171      = 8'd171;
  localparam logic [7:0] Lvl170      = 8'd170;
  localparam logic [7:0] Lvl85       = 8'd85;

  localparam logic [7:0] WgtR = 8'd255;
  localparam logic [7:0] WgtG = 8'd114;
  localparam logic [7:0] WgtB = 8'd40;

  typedef logic [7:0] chan_t;

  typedef enum logic [2:0] {
    SecRed    = 3'd0,
    SecOrange = 3'd1,
    SecYellow = 3'd2,
    SecGreen  = 3'd3,
    SecAqua   = 3'd4,
    SecBlue   = 3'd5,
    SecPurple = 3'd6,
    SecPink   = 3'd7
  } sect_e;

  // division state carried along the cell chain
  typedef struct packed {
    chan_t                  mx;
    logic [NumCh-1:0][7:0]  rem;
    logic [NumCh-1:0][7:0]  num_lo;
    logic [NumCh-1:0][7:0]  quo;
  } hw565_div_t;

endpackage

`default_nettype wire

// File: hdl/hue_wheel_to_rgb565.sv
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb565
// Maps an 8-bit hue to a full-brightness RGB565 colour.
// ----------------------------------------------------------------------------
// Input stream s_axis: one hue per item in s_axis_tdata.
// Output stream m_axis: one RGB565 colour per item in m_axis_tdata.
// cfg_we_i/cfg_wdata_i write the warm tint mix; write only when idle.
// Pipeline: 12 register stages
// (4 front stages: wheel, tint product, tint sum, max and set-up;
// then 8 division cells, one quotient bit per cell).
// One item per cycle unless stalled; every stage has its own valid bit.
// Stall: a stalled receiver holds the last cell; bubbles upstream still
// close up, so s_axis_tready drops only when all 12 stages are full.
// Reset: all stages empty, warm mix cleared to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hue_wheel_to_rgb565 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] hue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] color565
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import hw565_pkg::*;

  logic [7:0]   warm_mix_q;
  logic [DivSteps:0] cv, cr;
  hw565_div_t   cd [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_mix_q <= '0;
    end else if (cfg_we_i) begin
      warm_mix_q <= cfg_wdata_i;
    end
  end

  hw565_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hue_i       (s_axis_tdata),
    .warm_mix_i  (warm_mix_q),
    .out_valid_o (cv[0]),
    .out_ready_i (cr[0]),
    .out_data_o  (cd[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    hw565_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[k]),
      .in_ready_o  (cr[k]),
      .in_data_i   (cd[k]),
      .out_valid_o (cv[k+1]),
      .out_ready_i (cr[k+1]),
      .out_data_o  (cd[k+1])
    );
  end

  assign cr[DivSteps]  = m_axis_tready;
  assign m_axis_tvalid = cv[DivSteps];
  assign m_axis_tdata  = {cd[DivSteps].quo[ChR][7:3], cd[DivSteps].quo[ChG][7:2],
                          cd[DivSteps].quo[ChB][7:3]};

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input blocked while pipeline has room");

endmodule

`default_nettype wire

// File: hdl/hw565_front.sv
// ----------------------------------------------------------------------------
// hw565_front
// Hue to RGB, warm tint blend, channel maximum and division set-up.
// ----------------------------------------------------------------------------
`default_nettype none

module hw565_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         hue_i,
  input  logic [7:0]         warm_mix_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hw565_pkg::hw565_div_t out_data_o
);
  import hw565_pkg::*;

  logic [3:0] v_q;
  logic [4:0] rdy;

  logic [NumCh-1:0][7:0] a_d, a_q;
  logic [NumCh-1:0][7:0] bp_d, bp_q, bt_d, bt_q, bc_q;
  logic [NumCh-1:0][7:0] c_d, c_q;
  hw565_div_t            d_d, d_q;

  logic [7:0]  off;
  logic [15:0] prod_third, prod_twothird;
  chan_t       third, twothird;
  logic [7:0]  inv;
  logic [7:0]  wgt [NumCh];
  logic [15:0] pp [NumCh];
  logic [15:0] pt [NumCh];
  logic [15:0] pm [NumCh];
  logic [8:0]  sum [NumCh];
  logic [15:0] num [NumCh];
  chan_t       mx, mx_rg;

  assign rdy[4] = out_ready_i;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end
  assign in_ready_o = rdy[0];

  // hue wheel
  always_comb begin
    off           = {hue_i[4:0], 3'b000};
    prod_third    = off * ThirdMul;
    prod_twothird = off * TwoThirdMul;
    third         = prod_third[15:8];
    twothird      = prod_twothird[15:8];
    case (sect_e'(hue_i[7:5]))
      SecRed: begin
        a_d[ChR] = Lvl255 - third;    a_d[ChG] = third;             a_d[ChB] = '0;
      end
      SecOrange: begin
        a_d[ChR] = Lvl171;            a_d[ChG] = Lvl85 + third;     a_d[ChB] = '0;
      end
      SecYellow: begin
        a_d[ChR] = Lvl171 - twothird; a_d[ChG] = Lvl170 + third;    a_d[ChB] = '0;
      end
      SecGreen: begin
        a_d[ChR] = '0;                a_d[ChG] = Lvl255 - third;    a_d[ChB] = third;
      end
      SecAqua: begin
        a_d[ChR] = '0;                a_d[ChG] = Lvl171 - twothird; a_d[ChB] = Lvl85 + third;
      end
      SecBlue: begin
        a_d[ChR] = third;             a_d[ChG] = '0;                a_d[ChB] = Lvl255 - third;
      end
      SecPurple: begin
        a_d[ChR] = Lvl85 + third;     a_d[ChG] = '0;                a_d[ChB] = Lvl171 - third;
      end
      default: begin
        a_d[ChR] = Lvl170 + third;    a_d[ChG] = '0;                a_d[ChB] = Lvl85 - third;
      end
    endcase
  end

  // tint, first products
  always_comb begin
    inv      = Lvl255 - warm_mix_i;
    wgt[ChR] = WgtR;
    wgt[ChG] = WgtG;
    wgt[ChB] = WgtB;
    for (int i = 0; i < NumCh; i++) begin
      pp[i]   = a_q[i] * inv;
      pt[i]   = a_q[i] * wgt[i];
      bp_d[i] = pp[i][15:8];
      bt_d[i] = pt[i][15:8];
    end
  end

  // tint, second product and sum; a zero mix passes the wheel colour
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      pm[i]  = bt_q[i] * warm_mix_i;
      sum[i] = {1'b0, bp_q[i]} + {1'b0, pm[i][15:8]};
      c_d[i] = (warm_mix_i != '0) ? sum[i][7:0] : bc_q[i];
    end
  end

  // maximum and dividend set-up; black uses a unit divisor
  always_comb begin
    mx_rg = (c_q[ChR] > c_q[ChG]) ? c_q[ChR] : c_q[ChG];
    mx    = (c_q[ChB] > mx_rg) ? c_q[ChB] : mx_rg;
    d_d.mx = (mx == '0) ? 8'd1 : mx;
    for (int i = 0; i < NumCh; i++) begin
      num[i]       = {c_q[i], 8'h00} - {8'h00, c_q[i]};
      d_d.rem[i]    = num[i][15:8];
      d_d.num_lo[i] = num[i][7:0];
      d_d.quo[i]    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) a_q <= a_d;
    if (rdy[1]) begin
      bp_q <= bp_d;
      bt_q <= bt_d;
      bc_q <= a_q;
    end
    if (rdy[2]) c_q <= c_d;
    if (rdy[3]) d_q <= d_d;
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = d_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> (d_q.mx != '0))
    else $error("zero divisor handed to divider");

endmodule

`default_nettype wire

// File: hdl/hw565_div_cell.sv
// ----------------------------------------------------------------------------
// hw565_div_cell
// One restoring division step for all three channels, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hw565_div_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hw565_pkg::hw565_div_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hw565_pkg::hw565_div_t out_data_o
);
  import hw565_pkg::*;

  logic       valid_q;
  hw565_div_t data_d, data_q;
  logic [8:0] trial [NumCh];

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    data_d.mx = in_data_i.mx;
    for (int i = 0; i < NumCh; i++) begin
      trial[i]         = {in_data_i.rem[i], in_data_i.num_lo[i][7]};
      data_d.num_lo[i] = {in_data_i.num_lo[i][6:0], 1'b0};
      if (trial[i] >= {1'b0, in_data_i.mx}) begin
        data_d.rem[i] = 8'(trial[i] - {1'b0, in_data_i.mx});
        data_d.quo[i] = {in_data_i.quo[i][6:0], 1'b1};
      end else begin
        data_d.rem[i] = trial[i][7:0];
        data_d.quo[i] = {in_data_i.quo[i][6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q.rem[ChR] < data_q.mx) && (data_q.rem[ChG] < data_q.mx)
                && (data_q.rem[ChB] < data_q.mx))
    else $error("partial remainder not below divisor");

endmodule

`default_nettype wire

// File: tb/hue_wheel_to_rgb565_tb.sv
// ----------------------------------------------------------------------------
// hue_wheel_to_rgb565_tb
// Self-checking stream testbench for the hue wheel to RGB565 mapper.
// A directed table covers section edges and warm-mix extremes. Random hues
// follow under several warm-mix settings and idling patterns, plus one long
// receiver hold-off. Every output item is checked, in order, against the
// table colour or a local colour predictor.
// ----------------------------------------------------------------------------

module hue_wheel_to_rgb565_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hw565_pkg::*;

  localparam int unsigned PipeDepth  = 12;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned MaxPrints  = 20;

  typedef struct {
    logic [7:0]  hue;
    logic [7:0]  mix;
    bit          known;
    logic [15:0] color;
  } hue_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] hue
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [15:0] color565
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;

  logic [15:0] colour_q [$];
  logic [7:0]  mix_model   = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned err_cnt = 0;
  int unsigned hue_cnt = 0;
  int unsigned mix_cnt = 0;
  int unsigned idle_cnt = 0;

  hue_row_t hue_rows [24] = '{
    '{8'h00, 8'd0,   1'b1, 16'hF800},
    '{8'h1F, 8'd0,   1'b0, 16'h0000},
    '{8'h20, 8'd0,   1'b0, 16'h0000},
    '{8'h3F, 8'd0,   1'b0, 16'h0000},
    '{8'h40, 8'd0,   1'b0, 16'h0000},
    '{8'h5F, 8'd0,   1'b0, 16'h0000},
    '{8'h60, 8'd0,   1'b1, 16'h07E0},
    '{8'h7F, 8'd0,   1'b0, 16'h0000},
    '{8'h80, 8'd0,   1'b0, 16'h0000},
    '{8'h9F, 8'd0,   1'b0, 16'h0000},
    '{8'hA0, 8'd0,   1'b1, 16'h001F},
    '{8'hBF, 8'd0,   1'b0, 16'h0000},
    '{8'hC0, 8'd0,   1'b0, 16'h0000},
    '{8'hDF, 8'd0,   1'b0, 16'h0000},
    '{8'hE0, 8'd0,   1'b0, 16'h0000},
    '{8'hFF, 8'd0,   1'b0, 16'h0000},
    '{8'h10, 8'd0,   1'b0, 16'h0000},
    '{8'h00, 8'd255, 1'b1, 16'hF800},
    '{8'h60, 8'd255, 1'b0, 16'h0000},
    '{8'hA0, 8'd255, 1'b0, 16'h0000},
    '{8'hE0, 8'd255, 1'b0, 16'h0000},
    '{8'hFF, 8'd255, 1'b0, 16'h0000},
    '{8'h00, 8'd1,   1'b0, 16'h0000},
    '{8'h80, 8'd1,   1'b0, 16'h0000}
  };

  hue_wheel_to_rgb565 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] rgb565_of_hue(input logic [7:0] hue, input logic [7:0] mix);
    int unsigned off, third, twothird, r, g, b, mx, inv;
    sect_e sect;
    off      = {hue[4:0], 3'b000};
    third    = (off * ThirdMul) >> 8;
    twothird = (off * TwoThirdMul) >> 8;
    sect     = sect_e'(hue[7:5]);
    case (sect)
      SecRed: begin
        r = Lvl255 - third; g = third; b = 0;
      end
      SecOrange: begin
        r = Lvl171; g = Lvl85 + third; b = 0;
      end
      SecYellow: begin
        r = Lvl171 - twothird; g = Lvl170 + third; b = 0;
      end
      SecGreen: begin
        r = 0; g = Lvl255 - third; b = third;
      end
      SecAqua: begin
        r = 0; g = Lvl171 - twothird; b = Lvl85 + third;
      end
      SecBlue: begin
        r = third; g = 0; b = Lvl255 - third;
      end
      SecPurple: begin
        r = Lvl85 + third; g = 0; b = Lvl171 - third;
      end
      default: begin
        r = Lvl170 + third; g = 0; b = Lvl85 - third;
      end
    endcase
    if (mix != 0) begin
      inv = Lvl255 - mix;
      r = ((r * inv) >> 8) + ((((r * WgtR) >> 8) * mix) >> 8);
      g = ((g * inv) >> 8) + ((((g * WgtG) >> 8) * mix) >> 8);
      b = ((b * inv) >> 8) + ((((b * WgtB) >> 8) * mix) >> 8);
    end
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    // full-brightness stretch; black and already-full colours pass as they are
    if (mx > 0 && mx < Lvl255) begin
      r = r * Lvl255 / mx;
      g = g * Lvl255 / mx;
      b = b * Lvl255 / mx;
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (err_cnt < MaxPrints)
      $display("%0t ns: %s: color565 got %04h want %04h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic send_hue(input logic [7:0] hue, input bit known, input logic [15:0] color);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= hue;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    colour_q = {colour_q, (known ? color : rgb565_of_hue(hue, mix_model))};
    hue_cnt++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // warm mix is only written once the pipeline is empty
  task automatic set_warm_mix(input logic [7:0] mix);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mix_model   = mix;
    mix_cnt++;
  endtask

  task automatic run_random(input int unsigned n, input logic [7:0] mix,
                            input int unsigned send_pct, input int unsigned recv_pct);
    set_warm_mix(mix);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) send_hue(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (colour_q.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, '0);
      end else if (m_axis_tdata !== colour_q[0]) begin
        report_mismatch("mismatch", m_axis_tdata, colour_q.pop_front());
      end else begin
        void'(colour_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IdleLimit) begin
      $display("watchdog: no item moved for %0d cycles", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (hue_rows[i]) begin
      if (hue_rows[i].mix != mix_model || mix_cnt == 0) set_warm_mix(hue_rows[i].mix);
      send_hue(hue_rows[i].hue, hue_rows[i].known, hue_rows[i].color);
    end

    run_random(200, 8'd0,   0,  0);
    run_random(200, 8'd255, 57, 0);
    run_random(200, 8'd1,   0,  57);
    run_random(200, 8'($urandom_range(0, 255)), 16, 16);

    // long hold-off at the output while items keep coming
    set_warm_mix(8'd128);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    repeat (60) send_hue(8'($urandom_range(0, 255)), 1'b0, '0);

    run_random(200, 8'($urandom_range(1, 254)), 0, 0);
    run_random(200, 8'($urandom_range(0, 255)), 16, 16);

    drain();
    if (colour_q.size() != 0) report_mismatch("missing item", '0, colour_q[0]);
    $display("Sent %0d hues across %0d warm-mix writes (0, 1, 128, 255 and random).",
             hue_cnt, mix_cnt);
    $display("Idling: none, sender gaps, receiver stalls, both, and one long output hold.");
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
